// File: rtl/mmfn_pkg.sv
// mmfn_pkg: shared widths, codes and constants of the min-max feature normalizer
// used by the channel interfaces, the core and its checker
`default_nettype none

package mmfn_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 8;
  localparam int SCL_W = 17;
  localparam int FRAC_W = 16;

  typedef enum logic {
    FUNC_OBSERVE   = 1'b0,
    FUNC_NORMALIZE = 1'b1
  } func_e;

  localparam logic [SCL_W-1:0] SCALE_ZERO = '0;
  localparam logic [SCL_W-1:0] SCALE_ONE  = SCL_W'(1) << FRAC_W;

  typedef struct packed {
    logic [VAL_W-1:0] maximum;
    logic [VAL_W-1:0] minimum;
  } range_t;

endpackage

`default_nettype wire

// File: rtl/mmfn_in_if.sv
// mmfn_in_if: sample channel into the normalizer, valid/ready handshake
// depends on mmfn_pkg
`default_nettype none

interface mmfn_in_if;
  import mmfn_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] feature_index;
  logic [VAL_W-1:0] sample_value;
  logic             first_sample;

  modport source (output valid, func, feature_index, sample_value, first_sample,
                  input ready);
  modport sink   (input valid, func, feature_index, sample_value, first_sample,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/mmfn_out_if.sv
// mmfn_out_if: result channel out of the normalizer, valid/ready handshake
// depends on mmfn_pkg
`default_nettype none

interface mmfn_out_if;
  import mmfn_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_feature_index;
  logic [SCL_W-1:0] scaled_value;

  modport source (output valid, out_feature_index, scaled_value, input ready);
  modport sink   (input valid, out_feature_index, scaled_value, output ready);
endinterface

`default_nettype wire

// File: rtl/min_max_feature_normalizer_core.sv
// min_max_feature_normalizer_core: per-feature min/max store and Q1.16 scaler
// depends on mmfn_pkg, mmfn_in_if, mmfn_out_if
//
// Observe transactions (func 0) update the stored minimum and maximum of one
// feature by read-modify-write of a single-port-style synchronous memory of
// FEATURE_COUNT entries; a flagged first sample sets both. Normalize
// transactions (func 1) return floor((v-min)*65536/(max-min)) in 0..65536,
// 0 for a flat range or an index of FEATURE_COUNT or more. One transaction
// is in work at a time: an observe ends in ST_READ; a normalize whose result
// is 0 or 65536 goes from ST_READ to ST_DONE, any other runs the radix-2
// divider in ST_DIV, one quotient bit per cycle, before ST_DONE. A finished
// result waits in the output register while the next transaction is taken.
// Entries read before their first flagged observe return unspecified values.
`default_nettype none

module min_max_feature_normalizer_core #(
  parameter int FEATURE_COUNT = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mmfn_in_if.sink    in_i,
  mmfn_out_if.source out_o
);
  import mmfn_pkg::*;

  localparam int AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam logic [16:0] FC = 17'(FEATURE_COUNT);
  localparam int CNT_W = $clog2(FRAC_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  logic             func_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] val_q;
  logic             first_q;
  logic             ok_q;
  logic [VAL_W-1:0] rem_q;
  logic [VAL_W-1:0] div_q;
  logic [SCL_W-1:0] quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [SCL_W-1:0] out_val_q;

  range_t mem_q [FEATURE_COUNT];
  range_t rdata_q;
  range_t wdata;
  logic   in_acc;
  logic   mem_we;
  logic   idx_ok;

  logic [VAL_W:0]   rem_sh;
  logic             rem_ge;
  logic [VAL_W-1:0] rem_d;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_acc            = in_i.valid && in_i.ready;
  assign idx_ok            = 17'(in_i.feature_index) < FC;
  assign mem_we            = (state_q == ST_READ) && (func_q == FUNC_OBSERVE) && ok_q;
  assign out_o.valid             = out_valid_q;
  assign out_o.out_feature_index = out_idx_q;
  assign out_o.scaled_value      = out_val_q;

  // min/max update
  always_comb begin
    if (first_q) begin
      wdata.minimum = val_q;
      wdata.maximum = val_q;
    end else begin
      wdata.minimum = (val_q < rdata_q.minimum) ? val_q : rdata_q.minimum;
      wdata.maximum = (val_q > rdata_q.maximum) ? val_q : rdata_q.maximum;
    end
  end

  // restoring divider step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, div_q};
  assign rem_d  = rem_ge ? VAL_W'(rem_sh - {1'b0, div_q}) : rem_sh[VAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(idx_q)] <= wdata;
    end
    if (in_acc) begin
      rdata_q <= mem_q[AW'(in_i.feature_index)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            func_q  <= in_i.func;
            idx_q   <= in_i.feature_index;
            val_q   <= in_i.sample_value;
            first_q <= in_i.first_sample;
            ok_q    <= idx_ok;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (func_q == FUNC_OBSERVE) begin
            state_q <= ST_IDLE;
          end else if (!ok_q || rdata_q.maximum == rdata_q.minimum ||
                       val_q <= rdata_q.minimum) begin
            quot_q  <= SCALE_ZERO;
            state_q <= ST_DONE;
          end else if (val_q >= rdata_q.maximum) begin
            quot_q  <= SCALE_ONE;
            state_q <= ST_DONE;
          end else begin
            rem_q   <= val_q - rdata_q.minimum;
            div_q   <= rdata_q.maximum - rdata_q.minimum;
            quot_q  <= SCALE_ZERO;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          quot_q <= {quot_q[SCL_W-2:0], rem_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= idx_q;
            out_val_q   <= quot_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mmfn_checker.sv
// mmfn_checker: port-level assertions on the min-max feature normalizer
// depends on mmfn_pkg; bound to min_max_feature_normalizer_core below
`default_nettype none

module mmfn_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [mmfn_pkg::SCL_W-1:0] scaled_value_i
);
  import mmfn_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> scaled_value_i <= SCALE_ONE)
    else $error("scaled value above 1.0");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second transaction taken while one is in work");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result shown before memory read completed");

endmodule

bind min_max_feature_normalizer_core mmfn_checker u_mmfn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .scaled_value_i (out_o.scaled_value)
);

`default_nettype wire

// File: test/mmfn_normalizer_checker.sv
`timescale 1ns / 100ps
// mmfn_normalizer_checker: watches both channels of the min-max normalizer, keeps its own
// per-feature range store and compares every result with the predicted one
// depends on mmfn_pkg, mmfn_in_if and mmfn_out_if

module mmfn_normalizer_checker
  import mmfn_pkg::*;
#(
  parameter int FEATURE_COUNT = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  mmfn_in_if   in_mon_i,
  mmfn_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   observe_count_o,
  output int   normalize_count_o,
  output int   flat_count_o,
  output int   clip_count_o,
  output int   interior_count_o
);

  typedef struct {
    logic [IDX_W-1:0] feature_index;
    logic [SCL_W-1:0] scaled_value;
  } scaled_due_t;

  logic [VAL_W-1:0] seen_min [FEATURE_COUNT];
  logic [VAL_W-1:0] seen_max [FEATURE_COUNT];
  scaled_due_t      scaled_due_q [$];
  scaled_due_t      want;
  scaled_due_t      got;
  int unsigned      slot;

  assign pending_o = scaled_due_q.size();

  function automatic logic [SCL_W-1:0] norm_q16(logic [VAL_W-1:0] v, logic [VAL_W-1:0] lo,
                                                logic [VAL_W-1:0] hi);
    logic [VAL_W+FRAC_W-1:0] num;
    logic [VAL_W-1:0]        span;
    if (hi == lo || v <= lo) return SCALE_ZERO;
    if (v >= hi) return SCALE_ONE;
    num  = {VAL_W'(v - lo), FRAC_W'(0)};
    span = hi - lo;
    return SCL_W'(num / span);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fail_count_o      = 0;
      observe_count_o   = 0;
      normalize_count_o = 0;
      flat_count_o      = 0;
      clip_count_o      = 0;
      interior_count_o  = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.feature_index = out_mon_i.out_feature_index;
        got.scaled_value  = out_mon_i.scaled_value;
        if (scaled_due_q.size() == 0) begin
          if (fail_count_o < 20)
            $display("%0t: result with none due, feature_index %0d scaled_value %0d",
                     $time, got.feature_index, got.scaled_value);
          fail_count_o++;
        end else begin
          want = scaled_due_q.pop_front();
          if (got.feature_index !== want.feature_index) begin
            if (fail_count_o < 20)
              $display("%0t: out_feature_index expected %0d actual %0d",
                       $time, want.feature_index, got.feature_index);
            fail_count_o++;
          end
          if (got.scaled_value !== want.scaled_value) begin
            if (fail_count_o < 20)
              $display("%0t: scaled_value of feature %0d expected %0d actual %0d",
                       $time, want.feature_index, want.scaled_value, got.scaled_value);
            fail_count_o++;
          end
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        slot = in_mon_i.feature_index;
        if (in_mon_i.func == FUNC_OBSERVE) begin
          observe_count_o++;
          if (slot < FEATURE_COUNT) begin
            if (in_mon_i.first_sample) begin
              seen_min[slot] = in_mon_i.sample_value;
              seen_max[slot] = in_mon_i.sample_value;
            end else begin
              if (in_mon_i.sample_value < seen_min[slot]) seen_min[slot] = in_mon_i.sample_value;
              if (in_mon_i.sample_value > seen_max[slot]) seen_max[slot] = in_mon_i.sample_value;
            end
          end
        end else begin
          normalize_count_o++;
          want.feature_index = in_mon_i.feature_index;
          if (slot >= FEATURE_COUNT) begin
            want.scaled_value = SCALE_ZERO;
            flat_count_o++;
          end else begin
            want.scaled_value = norm_q16(in_mon_i.sample_value, seen_min[slot], seen_max[slot]);
            if (seen_min[slot] == seen_max[slot]) flat_count_o++;
            else if (in_mon_i.sample_value <= seen_min[slot] ||
                     in_mon_i.sample_value >= seen_max[slot]) clip_count_o++;
            else interior_count_o++;
          end
          scaled_due_q = {scaled_due_q, want};
        end
      end
    end
  end

endmodule

// File: test/tb_min_max_feature_normalizer_core.sv
`timescale 1ns / 100ps
// tb_min_max_feature_normalizer_core: stimulus, handshake idling and verdict for the
// min-max normalizer; depends on mmfn_pkg, both channel interfaces, the core and
// mmfn_normalizer_checker

module tb_min_max_feature_normalizer_core;
  import mmfn_pkg::*;

  localparam int FEATURES     = 1024;
  localparam int RANDOM_ITEMS = 1880;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mmfn_in_if  in_ch ();
  mmfn_out_if out_ch ();

  int fail_count;
  int pending;
  int observe_count;
  int normalize_count;
  int flat_count;
  int clip_count;
  int interior_count;

  bit               seeded   [FEATURES];
  logic [VAL_W-1:0] last_val [FEATURES];
  int unsigned      calm_left   = 0;
  int unsigned      sink_hold   = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      sent        = 0;

  always #4 clk_i = ~clk_i;

  min_max_feature_normalizer_core #(.FEATURE_COUNT(FEATURES)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mmfn_normalizer_checker #(.FEATURE_COUNT(FEATURES)) u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon_i          (in_ch),
    .out_mon_i         (out_ch),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .observe_count_o   (observe_count),
    .normalize_count_o (normalize_count),
    .flat_count_o      (flat_count),
    .clip_count_o      (clip_count),
    .interior_count_o  (interior_count)
  );

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send(func_e f, int unsigned idx, logic [VAL_W-1:0] v, logic first);
    int unsigned gap;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(99) < 3) calm_left = $urandom_range(80, 20);
      gap = stall_len();
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.feature_index <= IDX_W'(idx);
    in_ch.sample_value  <= v;
    in_ch.first_sample  <= first;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (f == FUNC_OBSERVE) begin
      if (first) seeded[idx] = 1'b1;
      last_val[idx] = v;
    end
    sent++;
  endtask

  task automatic random_item();
    int unsigned      idx;
    int unsigned      r;
    func_e            f;
    logic             first;
    logic [VAL_W-1:0] v;
    r = $urandom_range(99);
    if (r < 70) idx = $urandom_range(1) ? $urandom_range(7) : FEATURES - 1 - $urandom_range(7);
    else idx = $urandom_range(FEATURES - 1);
    if (!seeded[idx]) begin
      f     = FUNC_OBSERVE;
      first = 1'b1;
    end else begin
      f     = $urandom_range(1) ? FUNC_NORMALIZE : FUNC_OBSERVE;
      first = (f == FUNC_NORMALIZE) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
    end
    r = $urandom_range(99);
    if (r < 10) v = '0;
    else if (r < 20) v = '1;
    else if (r < 40 && seeded[idx]) v = last_val[idx];
    else v = VAL_W'($urandom);
    send(f, idx, v, first);
  endtask

  // output side stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) < 70);
      sink_hold    <= stall_len();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still due",
               $time, STALL_LIMIT, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_OBSERVE;
    in_ch.feature_index <= '0;
    in_ch.sample_value  <= '0;
    in_ch.first_sample  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flat range, full range, first flag on normalize
    send(FUNC_OBSERVE,   0,    8'd0,   1'b1);
    send(FUNC_NORMALIZE, 0,    8'd0,   1'b0);
    send(FUNC_NORMALIZE, 0,    8'd255, 1'b1);
    send(FUNC_OBSERVE,   0,    8'd255, 1'b0);
    send(FUNC_NORMALIZE, 0,    8'd0,   1'b0);
    send(FUNC_NORMALIZE, 0,    8'd255, 1'b0);
    send(FUNC_NORMALIZE, 0,    8'd128, 1'b0);
    send(FUNC_NORMALIZE, 0,    8'd1,   1'b0);
    send(FUNC_NORMALIZE, 0,    8'd254, 1'b1);
    // below and above the observed range, then re-seeded to a flat range
    send(FUNC_OBSERVE,   1023, 8'd100, 1'b1);
    send(FUNC_OBSERVE,   1023, 8'd200, 1'b0);
    send(FUNC_OBSERVE,   1023, 8'd150, 1'b0);
    send(FUNC_NORMALIZE, 1023, 8'd50,  1'b0);
    send(FUNC_NORMALIZE, 1023, 8'd250, 1'b0);
    send(FUNC_NORMALIZE, 1023, 8'd101, 1'b1);
    send(FUNC_OBSERVE,   1023, 8'd7,   1'b1);
    send(FUNC_NORMALIZE, 1023, 8'd7,   1'b0);
    // alternating index bits, range of one
    send(FUNC_OBSERVE,   682,  8'd170, 1'b1);
    send(FUNC_OBSERVE,   341,  8'd85,  1'b1);
    send(FUNC_OBSERVE,   341,  8'd86,  1'b0);
    send(FUNC_NORMALIZE, 341,  8'd85,  1'b0);
    send(FUNC_NORMALIZE, 341,  8'd86,  1'b0);
    send(FUNC_NORMALIZE, 682,  8'd171, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      random_item();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d transactions: %0d observes, %0d normalizes", sent, observe_count,
             normalize_count);
    $display("normalized: %0d flat range, %0d at or past a bound, %0d inside the range",
             flat_count, clip_count, interior_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mmfn_pkg.sv
rtl/mmfn_in_if.sv
rtl/mmfn_out_if.sv
rtl/min_max_feature_normalizer_core.sv
rtl/mmfn_checker.sv
test/mmfn_normalizer_checker.sv
test/tb_min_max_feature_normalizer_core.sv
